@@ rtl/bwq_pkg.sv @@
`default_nettype none
package bwq_pkg;

   localparam logic [1:0] FUNC_GRID   = 2'd0;
   localparam logic [1:0] FUNC_WEIGHT = 2'd1;
   localparam logic [1:0] FUNC_BAND   = 2'd2;
   localparam logic [1:0] FUNC_SAMPLE = 2'd3;

   localparam logic [1:0] CSR_METHOD     = 2'd0;
   localparam logic [1:0] CSR_GRID_LEN   = 2'd1;
   localparam logic [1:0] CSR_FILTER_CNT = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INACTIVE = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   localparam int DIVIDEND_W = 63;
   localparam int DIVISOR_W  = 32;

   localparam int DIV3_W    = 35;
   localparam int DIV3_STEP = 7;
   localparam int DIV3_ITER = DIV3_W / DIV3_STEP;
   localparam logic [DIV3_W-1:0] DIV3_BIAS   = 35'd25769803776;
   localparam logic [DIV3_W-1:0] DIV3_OFFSET = 35'd8589934592;

   localparam logic signed [31:0] FLUX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FLUX_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      OP_GRID,
      OP_WEIGHT,
      OP_BAND,
      OP_SAMPLE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               write;
      logic               trigger;
      logic [9:0]         sample_index;
      logic [3:0]         filter_number;
      logic signed [31:0] data_value;
      logic [10:0]        band_first;
      logic [10:0]        band_stop;
   } cmd_type;

   typedef struct packed {
      logic        method;
      logic [10:0] grid_length;
      logic [4:0]  filter_count;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] num;
      logic [DIVISOR_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_BAND,
      BK_CHECK,
      BK_READ,
      BK_MUL,
      BK_SAMPLE,
      BK_DIV3,
      BK_TERM,
      BK_ACC,
      BK_NORM,
      BK_NWAIT,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/bwq_front.sv @@
`default_nettype none
module bwq_front #(
   parameter int SAMPLES = 1024,
   parameter int FILTERS = 16
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [9:0]         req_sample_index,
   input  logic [3:0]         req_filter_number,
   input  logic signed [31:0] req_data_value,
   input  logic [10:0]        req_band_first,
   input  logic [10:0]        req_band_stop,
   input  logic               req_last_sample,
   input  logic               q_full,
   output logic               push,
   output bwq_pkg::cmd_type   cmd
);
   import bwq_pkg::*;

   logic idx_ok;
   logic fil_ok;
   logic keep;

   assign req_ready = !q_full;

   always_comb begin
      idx_ok            = 32'(req_sample_index) < SAMPLES;
      fil_ok            = 32'(req_filter_number) < FILTERS;
      cmd.sample_index  = req_sample_index;
      cmd.filter_number = req_filter_number;
      cmd.data_value    = req_data_value;
      cmd.band_first    = req_band_first;
      cmd.band_stop     = req_band_stop;
      cmd.trigger       = 1'b0;
      case (req_func)
         FUNC_GRID: begin
            cmd.op    = OP_GRID;
            cmd.write = 1'b1;
            keep      = idx_ok;
         end
         FUNC_WEIGHT: begin
            cmd.op    = OP_WEIGHT;
            cmd.write = 1'b1;
            keep      = idx_ok && fil_ok;
         end
         FUNC_BAND: begin
            cmd.op    = OP_BAND;
            cmd.write = 1'b1;
            keep      = fil_ok;
         end
         default: begin
            cmd.op      = OP_SAMPLE;
            cmd.write   = idx_ok;
            cmd.trigger = req_last_sample;
            keep        = idx_ok || req_last_sample;
         end
      endcase
      push = req_valid && req_ready && keep;
   end

endmodule
`default_nettype wire

@@ rtl/bwq_queue.sv @@
`default_nettype none
module bwq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bwq_pkg::cmd_type push_cmd,
   input  logic             pop,
   output bwq_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import bwq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;

   assign head  = slot_ff[rd_ff];
   assign empty = count_ff == '0;
   assign full  = count_ff == (PW+1)'(QUEUE_DEPTH);

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("push into full queue");

endmodule
`default_nettype wire

@@ rtl/bwq_div.sv @@
`default_nettype none
module bwq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bwq_pkg::div_req_type req,
   output bwq_pkg::div_rsp_type rsp
);
   import bwq_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    trial;

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[DIVIDEND_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIVIDEND_W);
         num_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            num_in = {num_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule
`default_nettype wire

@@ rtl/bwq_back.sv @@
`default_nettype none
module bwq_back #(
   parameter int SAMPLES = 1024,
   parameter int FILTERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bwq_pkg::cfg_type     cfg,
   input  bwq_pkg::cmd_type     q_cmd,
   input  logic                 q_empty,
   output logic                 q_pop,
   output bwq_pkg::div_req_type div_req,
   input  bwq_pkg::div_rsp_type div_rsp,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [3:0]           rsp_filter_id,
   output logic signed [31:0]   rsp_flux,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last_filter
);
   import bwq_pkg::*;

   localparam int AW  = $clog2(SAMPLES);
   localparam int FW  = (FILTERS > 1) ? $clog2(FILTERS) : 1;
   localparam int CW  = $clog2(FILTERS + 1);
   localparam int WAW = FW + AW;
   localparam int BW  = 11 + 11 + 32;
   localparam int D3C = $clog2(DIV3_ITER + 1);

   typedef struct packed {
      logic pop;
      logic grid_we;
      logic weight_we;
      logic band_we;
      logic spec_we;
      logic emit;
   } ctl_type;

   back_state_type state_ff, state_in;
   ctl_type        ctl;

   logic signed [31:0] grid_mem   [SAMPLES];
   logic signed [31:0] spec_mem   [SAMPLES];
   logic signed [31:0] weight_mem [2**WAW];
   logic [BW-1:0]      band_mem   [FILTERS];
   logic [FILTERS-1:0] valid_ff, valid_in;

   logic signed [31:0] grid_rd_ff, spec_rd_ff, weight_rd_ff;
   logic [BW-1:0]      band_rd_ff;
   logic               band_valid_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_id_ff;
   logic signed [31:0]  rsp_flux_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_last_ff;

   logic [CW-1:0]       f_ff;
   logic [10:0]         k_ff, r_ff, n_ff;
   logic signed [63:0]  acc_ff, prod_ff, tprod_ff;
   logic                ovf_ff;
   logic signed [31:0]  p1_ff, p2_ff, x1_ff, x2_ff, opa_ff, opb_ff, den_ff;
   logic [DIV3_W-1:0]   u_ff;
   logic [1:0]          rem3_ff;
   logic [D3C-1:0]      d3cnt_ff;
   logic signed [31:0]  res_flux_ff;
   logic [1:0]          res_status_ff;

   logic [AW-1:0]       q_addr, k_addr;
   logic [FW-1:0]       f_addr;
   logic [10:0]         len;
   logic [CW-1:0]       cnt;
   logic [10:0]         b_first, b_stop;
   logic signed [31:0]  b_den;
   logic                inactive;
   logic signed [63:0]  ps;
   logic                p_sat;
   logic signed [31:0]  p;
   logic [32:0]         d1, d2;
   logic                dx1_sat, dx2_sat;
   logic signed [31:0]  dx1, dx2, h;
   logic [32:0]         s33;
   logic [DIV3_W-1:0]   v, t, u_init;
   logic [10:0]         pair_end;
   logic                last, do_trap, do_simp, sample_ovf;
   logic [1:0]          r3;
   logic [DIV3_W-1:0]   w3, m35;
   logic [2:0]          t3;
   logic signed [31:0]  m;
   logic signed [63:0]  term;
   logic                acc_big, neg, over, emit_ok;
   logic [63:0]         mag;
   logic [DIVIDEND_W-1:0] qs;
   logic signed [31:0]  flux_div;
   logic [1:0]          status_div;
   logic [CW-1:0]       f_next;

   assign q_addr = AW'(q_cmd.sample_index);
   assign k_addr = AW'(k_ff);
   assign f_addr = FW'(f_ff);
   assign q_pop  = ctl.pop;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filter_id   = rsp_id_ff;
   assign rsp_flux        = rsp_flux_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_filter = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (ctl.grid_we) begin
         grid_mem[q_addr] <= q_cmd.data_value;
      end
      grid_rd_ff <= grid_mem[k_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.spec_we) begin
         spec_mem[q_addr] <= q_cmd.data_value;
      end
      spec_rd_ff <= spec_mem[k_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.weight_we) begin
         weight_mem[{FW'(q_cmd.filter_number), q_addr}] <= q_cmd.data_value;
      end
      weight_rd_ff <= weight_mem[{f_addr, k_addr}];
   end

   always_ff @(posedge clock) begin
      if (ctl.band_we) begin
         band_mem[FW'(q_cmd.filter_number)] <=
            {q_cmd.band_first, q_cmd.band_stop, q_cmd.data_value};
      end
      band_rd_ff       <= band_mem[f_addr];
      band_valid_rd_ff <= valid_ff[f_addr];
   end

   // datapath combinational
   always_comb begin
      len = (32'(cfg.grid_length) > SAMPLES) ? 11'(SAMPLES) : cfg.grid_length;
      cnt = (32'(cfg.filter_count) > FILTERS) ? CW'(FILTERS) : CW'(cfg.filter_count);
      f_next = CW'(f_ff + 1'b1);

      b_first = band_valid_rd_ff ? band_rd_ff[53:43] : '0;
      b_stop  = band_valid_rd_ff ? band_rd_ff[42:32] : '0;
      b_den   = band_valid_rd_ff ? band_rd_ff[31:0] : '0;
      inactive = (b_den == 0) || (b_first > b_stop) || (b_stop > len)
                 || (11'(b_stop - b_first) < 11'd2);

      ps    = prod_ff >>> 16;
      p_sat = !((&ps[63:31]) || !(|ps[63:31]));
      p     = p_sat ? (ps[63] ? FLUX_MIN : FLUX_MAX) : ps[31:0];

      d1      = {grid_rd_ff[31], grid_rd_ff} - {x1_ff[31], x1_ff};
      dx1_sat = d1[32] != d1[31];
      dx1     = dx1_sat ? (d1[32] ? FLUX_MIN : FLUX_MAX) : d1[31:0];
      d2      = {grid_rd_ff[31], grid_rd_ff} - {x2_ff[31], x2_ff};
      dx2_sat = d2[32] != d2[31];
      dx2     = dx2_sat ? (d2[32] ? FLUX_MIN : FLUX_MAX) : d2[31:0];

      s33 = {p1_ff[31], p1_ff} + {p[31], p};
      h   = s33[32:1];

      v      = {{3{p2_ff[31]}}, p2_ff} + {p1_ff[31], p1_ff, 2'b00} + {{3{p[31]}}, p};
      t      = {v[DIV3_W-1], v[DIV3_W-1:1]};
      u_init = t + DIV3_BIAS;

      pair_end = (n_ff - 11'd1) & 11'h7FE;
      last     = r_ff == n_ff - 11'd1;
      do_simp  = cfg.method && !r_ff[0] && (r_ff >= 11'd2) && (r_ff <= pair_end);
      do_trap  = (!cfg.method && (r_ff != '0)) || (cfg.method && !n_ff[0] && last);
      sample_ovf = p_sat || (do_trap && dx1_sat) || (do_simp && dx2_sat);

      // long division by three, a few quotient bits per cycle
      r3 = rem3_ff;
      w3 = u_ff;
      t3 = '0;
      for (int i = 0; i < DIV3_STEP; i++) begin
         t3 = {r3, w3[DIV3_W-1]};
         w3 = {w3[DIV3_W-2:0], 1'b0};
         if (t3 >= 3'd3) begin
            r3    = 2'(t3 - 3'd3);
            w3[0] = 1'b1;
         end else begin
            r3 = t3[1:0];
         end
      end
      m35 = w3 - DIV3_OFFSET;
      m   = m35[31:0];

      term = tprod_ff >>> 16;

      acc_big = (acc_ff >= 64'sd140737488355328) || (acc_ff <= -64'sd140737488355328);
      neg     = acc_ff[63] ^ den_ff[31];
      mag     = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);

      over = neg ? (div_rsp.quot > DIVIDEND_W'(33'h0_8000_0000))
                 : (div_rsp.quot > DIVIDEND_W'(33'h0_7FFF_FFFF));
      qs   = neg ? DIVIDEND_W'(-div_rsp.quot) : div_rsp.quot;
      flux_div   = over ? (neg ? FLUX_MIN : FLUX_MAX) : qs[31:0];
      status_div = (ovf_ff || over) ? STATUS_SAT : STATUS_OK;

      emit_ok = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_cmd.trigger && (cnt != '0)) begin
               state_in = BK_BAND;
            end
         end
         BK_BAND:  state_in = BK_CHECK;
         BK_CHECK: state_in = inactive ? BK_EMIT : BK_READ;
         BK_READ:  state_in = BK_MUL;
         BK_MUL:   state_in = BK_SAMPLE;
         BK_SAMPLE: begin
            if (do_simp) begin
               state_in = BK_DIV3;
            end else if (do_trap) begin
               state_in = BK_TERM;
            end else if (last) begin
               state_in = BK_NORM;
            end else begin
               state_in = BK_READ;
            end
         end
         BK_DIV3: begin
            if (d3cnt_ff == D3C'(DIV3_ITER - 1)) begin
               state_in = BK_TERM;
            end
         end
         BK_TERM: state_in = BK_ACC;
         BK_ACC:  state_in = last ? BK_NORM : BK_READ;
         BK_NORM: state_in = acc_big ? BK_EMIT : BK_NWAIT;
         BK_NWAIT: begin
            if (div_rsp.done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (emit_ok) begin
               state_in = (f_next == cnt) ? BK_IDLE : BK_BAND;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      ctl           = '0;
      div_req.start = 1'b0;
      div_req.num   = {mag[46:0], 16'b0};
      div_req.den   = den_ff[31] ? DIVISOR_W'(-den_ff) : DIVISOR_W'(den_ff);
      case (state_ff)
         BK_IDLE: begin
            ctl.pop       = !q_empty;
            ctl.grid_we   = ctl.pop && q_cmd.op == OP_GRID;
            ctl.weight_we = ctl.pop && q_cmd.op == OP_WEIGHT;
            ctl.band_we   = ctl.pop && q_cmd.op == OP_BAND;
            ctl.spec_we   = ctl.pop && q_cmd.op == OP_SAMPLE && q_cmd.write;
         end
         BK_NORM:  div_req.start = !acc_big;
         BK_EMIT:  ctl.emit = emit_ok;
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.band_we) begin
         valid_in[FW'(q_cmd.filter_number)] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_id_ff     <= 4'(f_ff);
         rsp_flux_ff   <= res_flux_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= f_next == cnt;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: f_ff <= '0;
         BK_CHECK: begin
            k_ff          <= b_first;
            r_ff          <= '0;
            n_ff          <= b_stop - b_first;
            acc_ff        <= '0;
            ovf_ff        <= 1'b0;
            den_ff        <= b_den;
            res_flux_ff   <= '0;
            res_status_ff <= STATUS_INACTIVE;
         end
         BK_MUL: prod_ff <= spec_rd_ff * weight_rd_ff;
         BK_SAMPLE: begin
            p1_ff  <= p;
            p2_ff  <= p1_ff;
            x1_ff  <= grid_rd_ff;
            x2_ff  <= x1_ff;
            ovf_ff <= ovf_ff | sample_ovf;
            if (do_simp) begin
               opa_ff   <= dx2;
               u_ff     <= u_init;
               rem3_ff  <= '0;
               d3cnt_ff <= '0;
            end else begin
               opa_ff <= dx1;
               opb_ff <= h;
            end
            if (!do_simp && !do_trap) begin
               k_ff <= k_ff + 11'd1;
               r_ff <= r_ff + 11'd1;
            end
         end
         BK_DIV3: begin
            u_ff     <= w3;
            rem3_ff  <= r3;
            d3cnt_ff <= d3cnt_ff + 1'b1;
            opb_ff   <= m;
         end
         BK_TERM: tprod_ff <= opa_ff * opb_ff;
         BK_ACC: begin
            acc_ff <= acc_ff + term;
            k_ff   <= k_ff + 11'd1;
            r_ff   <= r_ff + 11'd1;
         end
         BK_NORM: begin
            if (acc_big) begin
               res_flux_ff   <= neg ? FLUX_MIN : FLUX_MAX;
               res_status_ff <= STATUS_SAT;
            end
         end
         BK_NWAIT: begin
            if (div_rsp.done) begin
               res_flux_ff   <= flux_div;
               res_status_ff <= status_div;
            end
         end
         BK_EMIT: begin
            if (ctl.emit) begin
               f_ff <= f_next;
            end
         end
         default: ;
      endcase
   end

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_INACTIVE |-> rsp_flux_ff == '0)
      else $error("inactive result with nonzero flux");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != BK_IDLE |-> !q_pop)
      else $error("queue popped during integration");

endmodule
`default_nettype wire

@@ rtl/band_weighted_quadrature.sv @@
// Band-weighted quadrature: photometry of streamed spectra over filter bands.
// req_ channel: one beat per load or spectrum sample (req_func selects grid
// point, filter weight, band descriptor or sample). Out-of-range loads are
// dropped. A sample beat with req_last_sample set starts integration.
// rsp_ channel: one beat per filter, in filter order, rsp_last_filter on the
// final one. csr_ channel writes method, grid length and filter count; it is
// always ready and must be used only while the block is idle.
// Load beats pass a 4-entry queue and retire one per cycle while the engine
// is idle. On the last sample each active filter reads and checks its band,
// then per band sample reads, multiplies and scales, adds a trapezoid or
// Simpson term (a Simpson pair first divides by three), and normalizes the
// sum in the bit-serial divider, skipped when the sum is out of range. An
// inactive filter reads, checks and emits only. The shared multiply-
// accumulate sequencer and the divider do this work. The first result comes
// after beats queued ahead of the last sample and after filter 0 is done.
// Reset clears configuration to defaults and all band descriptors, so every
// filter starts inactive. Grid, weight and spectrum stores are not cleared.
// A stalled receiver holds the result register; the engine finishes the next
// filter and waits, and the queue keeps taking beats until it fills.
`default_nettype none
module band_weighted_quadrature #(
   parameter int SAMPLES = 1024,
   parameter int FILTERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [9:0]         req_sample_index,
   input  logic [3:0]         req_filter_number,
   input  logic signed [31:0] req_data_value,
   input  logic [10:0]        req_band_first,
   input  logic [10:0]        req_band_stop,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_filter_id,
   output logic signed [31:0] rsp_flux,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_filter,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import bwq_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   cmd_type     push_cmd, head;
   logic        push, pop, q_empty, q_full;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_METHOD:     cfg_in.method       = csr_data[0];
            CSR_GRID_LEN:   cfg_in.grid_length  = csr_data[10:0];
            CSR_FILTER_CNT: cfg_in.filter_count = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method       <= 1'b0;
         cfg_ff.grid_length  <= 11'd1024;
         cfg_ff.filter_count <= 5'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bwq_front #(.SAMPLES(SAMPLES), .FILTERS(FILTERS)) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_sample_index  (req_sample_index),
      .req_filter_number (req_filter_number),
      .req_data_value    (req_data_value),
      .req_band_first    (req_band_first),
      .req_band_stop     (req_band_stop),
      .req_last_sample   (req_last_sample),
      .q_full            (q_full),
      .push              (push),
      .cmd               (push_cmd)
   );

   bwq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   bwq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bwq_back #(.SAMPLES(SAMPLES), .FILTERS(FILTERS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_cmd           (head),
      .q_empty         (q_empty),
      .q_pop           (pop),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_filter_id   (rsp_filter_id),
      .rsp_flux        (rsp_flux),
      .rsp_status      (rsp_status),
      .rsp_last_filter (rsp_last_filter)
   );

endmodule
`default_nettype wire
